// File: hw/rtl/nllp_pkg.sv
// shared constants, types and helpers for the numbered list line parser
package nllp_pkg;

	localparam int MAX_INDEX = 1024;
	localparam int IDX_W = 11;
	localparam int ADDR_W = $clog2(MAX_INDEX);
	localparam int EPOCH_W = 8;
	localparam int EPOCH_MAX = (1 << EPOCH_W) - 1;
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W = $clog2(Q_DEPTH);
	localparam int QCNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_VT = 8'h0b;
	localparam logic [7:0] CH_FF = 8'h0c;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_N = 8'h6e;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [7:0] data;
		logic done;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t [1:0] r;
	} res_pair_t;

	typedef struct packed {
		logic wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
		logic clear;
	} seen_ctl_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} seen_sts_t;

	function automatic res_t nllp_mk(logic [IDX_W-1:0] index, logic [7:0] data, logic done);
		res_t r;
		r.index = index;
		r.data = data;
		r.done = done;
		return r;
	endfunction

endpackage

// File: hw/rtl/nllp_seen.sv
// seen-index memory with epoch tags and clearing sweep
module nllp_seen (
	input logic clk,
	input logic arst_n,
	input nllp_pkg::seen_ctl_t ctl,
	output nllp_pkg::seen_sts_t sts
);
	import nllp_pkg::*;

	logic [EPOCH_W-1:0] mem [MAX_INDEX];
	logic [EPOCH_W-1:0] rd_data_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic sweep_q;
	logic [ADDR_W-1:0] sweep_cnt_q;

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			mem[sweep_cnt_q] <= '0;
		end else if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= epoch_q;
		end
		rd_data_q <= mem[ctl.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b1;
			sweep_cnt_q <= '0;
			epoch_q <= EPOCH_W'(1);
		end else if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
			if (sweep_cnt_q == ADDR_W'(MAX_INDEX - 1)) begin
				sweep_q <= 1'b0;
			end
		end else if (ctl.clear) begin
			if (epoch_q == EPOCH_W'(EPOCH_MAX)) begin
				// tags would wrap: wipe the memory and restart
				sweep_q <= 1'b1;
				sweep_cnt_q <= '0;
				epoch_q <= EPOCH_W'(1);
			end else begin
				epoch_q <= epoch_q + EPOCH_W'(1);
			end
		end
	end

	assign sts.busy = sweep_q;
	assign sts.hit = (rd_data_q == epoch_q);

endmodule

// File: hw/rtl/nllp_parse.sv
// line parser state and per-byte result generation
module nllp_parse (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] c,
	input logic eor,
	input logic seen_hit,
	output nllp_pkg::res_pair_t res,
	output nllp_pkg::seen_ctl_t ctl
);
	import nllp_pkg::*;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_DIGITS,
		PH_SKIP,
		PH_TEXT,
		PH_DROP
	} phase_t;

	phase_t phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic big_q, big_d;
	logic pcr_q, pcr_d;
	logic pb_q, pb_d;

	logic [1:0] n;
	logic go;
	logic is_digit;
	logic is_ws;
	logic is_punct;
	logic is_lead_ws;
	logic [13:0] prod;

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		big_d = big_q;
		pcr_d = pcr_q;
		pb_d = pb_q;
		n = 2'd0;
		go = 1'b0;
		res = '0;
		ctl.wr_en = 1'b0;
		ctl.clear = 1'b0;
		ctl.wr_addr = ADDR_W'(idx_q - IDX_W'(1));

		is_digit = (c >= CH_0) && (c <= CH_9);
		is_ws = (c == CH_SP) || (c == CH_TAB);
		is_punct = (c == CH_DOT) || (c == CH_RPAR) || (c == CH_COLON);
		is_lead_ws = is_ws || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
		prod = {3'b000, idx_q} * 14'd10 + {10'd0, c[3:0]};

		if (eor || (c == CH_LF)) begin
			if ((phase_q == PH_SKIP) || (phase_q == PH_TEXT)) begin
				if (pb_q) begin
					res.r[n[0]] = nllp_mk(idx_q, CH_BSL, 1'b0);
					n = n + 2'd1;
				end
				res.r[n[0]] = nllp_mk(idx_q, CH_NUL, 1'b1);
				n = n + 2'd1;
			end
			pb_d = 1'b0;
			pcr_d = 1'b0;
			phase_d = PH_LEAD;
			ctl.clear = eor;
		end else begin
			unique case (phase_q)
				PH_LEAD: begin
					if (is_digit) begin
						idx_d = {7'd0, c[3:0]};
						big_d = 1'b0;
						phase_d = PH_DIGITS;
					end else if (!is_lead_ws) begin
						phase_d = PH_DROP;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						if (!big_q) begin
							idx_d = prod[IDX_W-1:0];
							if (prod > 14'(MAX_INDEX)) begin
								big_d = 1'b1;
							end
						end
					end else if (is_punct || is_ws) begin
						if (!big_q && (idx_q != '0) && !seen_hit) begin
							ctl.wr_en = 1'b1;
							pb_d = 1'b0;
							pcr_d = 1'b0;
							phase_d = PH_SKIP;
						end else begin
							phase_d = PH_DROP;
						end
					end else begin
						phase_d = PH_DROP;
					end
				end
				PH_SKIP, PH_TEXT: begin
					if (!((phase_q == PH_SKIP) && is_ws)) begin
						phase_d = PH_TEXT;
						if (pb_q) begin
							pb_d = 1'b0;
							if (c == CH_N) begin
								res.r[n[0]] = nllp_mk(idx_q, CH_LF, 1'b0);
								n = n + 2'd1;
							end else begin
								res.r[n[0]] = nllp_mk(idx_q, CH_BSL, 1'b0);
								n = n + 2'd1;
								go = 1'b1;
							end
						end else begin
							if (pcr_q) begin
								pcr_d = 1'b0;
								res.r[n[0]] = nllp_mk(idx_q, CH_CR, 1'b0);
								n = n + 2'd1;
							end
							go = 1'b1;
						end
						if (go) begin
							if (c == CH_BSL) begin
								pb_d = 1'b1;
							end else if (c == CH_CR) begin
								pcr_d = 1'b1;
							end else begin
								res.r[n[0]] = nllp_mk(idx_q, c, 1'b0);
								n = n + 2'd1;
							end
						end
					end
				end
				default: begin
					phase_d = PH_DROP;
				end
			endcase
		end

		res.n = n;
		if (!step) begin
			res.n = 2'd0;
			ctl.wr_en = 1'b0;
			ctl.clear = 1'b0;
		end
		// read ahead at the index the next byte will see
		ctl.rd_addr = step ? ADDR_W'(idx_d - IDX_W'(1)) : ADDR_W'(idx_q - IDX_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			idx_q <= '0;
			big_q <= 1'b0;
			pcr_q <= 1'b0;
			pb_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			big_q <= big_d;
			pcr_q <= pcr_d;
			pb_q <= pb_d;
		end
	end

endmodule

// File: hw/rtl/nllp_outq.sv
// small result queue taking up to two words per cycle
module nllp_outq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input nllp_pkg::res_pair_t pair,
	output logic room,
	output logic out_valid,
	input logic out_stall,
	output logic [nllp_pkg::IDX_W-1:0] item_index,
	output logic [7:0] text_byte,
	output logic item_done
);
	import nllp_pkg::*;

	res_t ent_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [1:0] n_eff;
	logic pop;

	assign n_eff = push ? pair.n : 2'd0;
	assign pop = out_valid && !out_stall;
	assign room = cnt_q <= QCNT_W'(Q_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (n_eff != 2'd0) begin
			ent_q[wr_q] <= pair.r[0];
		end
		if (n_eff == 2'd2) begin
			ent_q[wr_q + QPTR_W'(1)] <= pair.r[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + QPTR_W'(n_eff);
			rd_q <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(n_eff) - QCNT_W'(pop);
		end
	end

	assign out_valid = cnt_q != '0;
	assign item_index = ent_q[rd_q].index;
	assign text_byte = ent_q[rd_q].data;
	assign item_done = ent_q[rd_q].done;

endmodule

// File: hw/rtl/numbered_list_line_parser_core.sv
// top level of the numbered list line parser
// Input channel: one word per reply byte (data_byte_in), or an end-of-reply word
// (end_of_reply = 1) that closes the last line and forgets all seen indices.
// Output channel: one word per kept text byte tagged with item_index, and a word
// with item_done = 1 at the end of each kept line.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Each accepted input word is registered, then parsed into the result queue.
// Throughput: one input word per cycle while each word makes at most one result
// and no stall holds the flow; words making two results (held backslash or
// carriage return flushed) outpace the queue's single output port and stall
// the input. Seen indices live in a 1024-entry tag memory, read ahead through
// a register. After reset, and after every 255th end-of-reply word, a clearing
// sweep over all 1024 entries runs; during it at most one input word is taken
// in and held. When the receiver stalls, the four-entry result queue fills and
// the input then stalls too; no word is lost or repeated.
module numbered_list_line_parser_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte_in,
	input logic end_of_reply,
	output logic out_valid,
	input logic out_stall,
	output logic [nllp_pkg::IDX_W-1:0] item_index,
	output logic [7:0] text_byte,
	output logic item_done
);
	import nllp_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eor_s1;
	logic step;
	logic room;
	logic load;
	res_pair_t pair;
	seen_ctl_t ctl;
	seen_sts_t sts;

	assign step = valid_s1 && !sts.busy && room;
	assign in_stall = valid_s1 && !step;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= data_byte_in;
			eor_s1 <= end_of_reply;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	nllp_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.c(byte_s1),
		.eor(eor_s1),
		.seen_hit(sts.hit),
		.res(pair),
		.ctl(ctl)
	);

	nllp_seen u_seen (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.sts(sts)
	);

	nllp_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(step),
		.pair(pair),
		.room(room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.item_index(item_index),
		.text_byte(text_byte),
		.item_done(item_done)
	);

	a_done_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_done |-> text_byte == CH_NUL)
		else $error("end-of-item word carries a data byte");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (item_index != '0) && (item_index <= IDX_W'(MAX_INDEX)))
		else $error("result index out of range");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !ctl.wr_en && !ctl.clear)
		else $error("seen memory updated during clearing sweep");

endmodule
